>>> hdl/pns_pkg.sv
// Shared types and constants for the paletted nearest-neighbor scaler.
`timescale 1ns / 1ps

package pns_pkg;

	localparam int CFG_W  = 11;           // src_cols / src_rows register width
	localparam int CNT_W  = 11;           // column and source row counters
	localparam int ACC_W  = 19;           // row accumulator
	localparam int BASE_W = 20;           // source row times output size
	localparam int DIV_W  = 27;           // cols * 0x10000
	localparam int FRAC_W = 28;           // 12.16 column position
	localparam int IDX_W  = FRAC_W - 16;  // integer part of the column position
	localparam int EXT_W  = 13;           // wide enough to hold MAX_COLS / MAX_ROWS up to 8191

	// register indexes on the configuration port
	localparam logic REG_SRC_COLS = 1'b0;
	localparam logic REG_SRC_ROWS = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  palette_index;
		logic [31:0] palette_color;
		logic [7:0]  pixel;
	} pns_item_t;

	typedef struct packed {
		logic [7:0]  out_row;
		logic [5:0]  out_group;
		logic [31:0] color0;
		logic [31:0] color1;
		logic [31:0] color2;
		logic [31:0] color3;
		logic        row_last;
		logic        frame_end;
	} pns_result_t;

	typedef struct packed {
		logic div_start;
		logic look_init;
		logic issue;
		logic load_out;
	} pns_cmd_t;

	typedef struct packed {
		logic fire;
		logic div_done;
		logic k_last;
		logic pipe_busy;
		logic out_free;
		logic group_last;
	} pns_sts_t;

endpackage

>>> hdl/pns_div.sv
// Column step unit: cols * 0x10000 / OUT_SIZE as a shift, done is registered from start.
`timescale 1ns / 1ps

module pns_div import pns_pkg::*; #(
	parameter int OUT_SIZE = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CFG_W-1:0] cols,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	// OUT_SIZE must be a power of two (not checked here), so the division is a right shift
	localparam int SH = $clog2(OUT_SIZE);

	logic [DIV_W-1:0] quot_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			quot_q <= {cols, 16'b0} >> SH;
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hdl/pns_dp.sv
// Datapath: counters, row and palette memories, lookup pipeline, output register.
`timescale 1ns / 1ps

module pns_dp import pns_pkg::*; #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024,
	parameter int OUT_SIZE = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  pns_item_t        item,
	input  logic [CFG_W-1:0] src_cols,
	input  logic [CFG_W-1:0] src_rows,
	input  pns_cmd_t         cmd,
	output pns_sts_t         sts,
	output logic             result_valid,
	input  logic             result_ready,
	output pns_result_t      result
);

	localparam int AW     = $clog2(MAX_COLS);
	localparam int OW     = $clog2(OUT_SIZE) + 1;
	localparam int NGROUP = OUT_SIZE / 4;
	localparam int GW     = $clog2(NGROUP);
	localparam logic [EXT_W-1:0]  MAX_COLS_X = EXT_W'(MAX_COLS);
	localparam logic [EXT_W-1:0]  MAX_ROWS_X = EXT_W'(MAX_ROWS);
	localparam logic [OW-1:0]     OUT_O      = OW'(OUT_SIZE);
	localparam logic [CNT_W-1:0]  OUT_C      = CNT_W'(OUT_SIZE);
	localparam logic [BASE_W-1:0] OUT_B      = BASE_W'(OUT_SIZE);
	localparam logic [GW-1:0]     GRP_LAST   = GW'(NGROUP - 1);

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [EXT_W-1:0] lim);
		logic [EXT_W-1:0] vx;
		vx = EXT_W'(v);
		if (v == '0)
			return CFG_W'(1);
		if (vx > lim)
			return lim[CFG_W-1:0];
		return v;
	endfunction

	logic [7:0]  row_mem [MAX_COLS];
	logic [31:0] pal_mem [256];

	logic [CNT_W-1:0]  cc_q;
	logic [CNT_W-1:0]  src_q;
	logic [OW-1:0]     orc_q;
	logic [ACC_W-1:0]  acc_q;
	logic [BASE_W-1:0] base_q;
	logic [7:0]        orow_q;
	logic              last_q;

	logic [CFG_W-1:0]  cols;
	logic [CFG_W-1:0]  rows;
	logic              accept;
	logic              pix;
	logic [CNT_W-1:0]  cc_nx;
	logic [EXT_W-1:0]  cc_x;
	logic [CNT_W-1:0]  src_nx;
	logic              row_done;
	logic              frame_done;
	logic              few_rows;
	logic              emit_small;
	logic              emit_big;
	logic [BASE_W-1:0] acc_x;
	logic              sel;
	logic              fire;
	logic              last_big;

	logic [DIV_W-1:0]  quot;
	logic              div_done;
	logic [FRAC_W-1:0] step_x;
	logic [FRAC_W-1:0] frac_q;
	logic [GW-1:0]     grp_q;
	logic [1:0]        k_q;
	logic [IDX_W-1:0]  idx;
	logic              oob;

	logic              v_s1;
	logic [1:0]        k_s1;
	logic              oob_s1;
	logic [7:0]        row_dat_s1;
	logic              v_s2;
	logic [1:0]        k_s2;
	logic [31:0]       pal_dat_s2;
	logic [31:0]       col_q [4];

	pns_result_t       res_q;
	logic              res_valid_q;
	logic              grp_is_last;

	assign cols   = clamp_size(src_cols, MAX_COLS_X);
	assign rows   = clamp_size(src_rows, MAX_ROWS_X);
	assign accept = item_valid && item_ready;
	assign pix    = accept && item.kind;

	assign cc_nx      = cc_q + 1'b1;
	assign cc_x       = EXT_W'(cc_q);
	assign row_done   = cc_nx >= cols;
	assign src_nx     = src_q + 1'b1;
	assign frame_done = src_nx >= rows;

	// with few rows each source row maps to its own output row; otherwise
	// source row s is selected when s*OUT_SIZE <= acc < (s+1)*OUT_SIZE
	assign few_rows   = rows <= OUT_C;
	assign emit_small = CNT_W'(orc_q) == src_q;
	assign acc_x      = BASE_W'(acc_q);
	assign emit_big   = (acc_x >= base_q) && (acc_x < base_q + OUT_B);
	assign sel        = (orc_q < OUT_O) && (few_rows ? emit_small : emit_big);
	assign fire       = pix && row_done && sel;
	assign last_big   = OW'(orc_q + 1'b1) == OUT_O;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			src_q  <= '0;
			orc_q  <= '0;
			acc_q  <= '0;
			base_q <= '0;
		end else if (pix) begin
			if (row_done) begin
				cc_q <= '0;
				if (frame_done) begin
					src_q  <= '0;
					orc_q  <= '0;
					acc_q  <= '0;
					base_q <= '0;
				end else begin
					src_q  <= src_nx;
					base_q <= base_q + OUT_B;
					if (sel) begin
						orc_q <= orc_q + 1'b1;
						if (!few_rows)
							acc_q <= acc_q + ACC_W'(rows);
					end
				end
			end else begin
				cc_q <= cc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			orow_q <= 8'(orc_q);
			last_q <= few_rows ? frame_done : last_big;
		end
	end

	pns_div #(
		.OUT_SIZE(OUT_SIZE)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.cols  (cols),
		.done  (div_done),
		.quot  (quot)
	);

	assign step_x = FRAC_W'(quot);
	assign idx    = frac_q[FRAC_W-1:16];
	assign oob    = EXT_W'(idx) >= MAX_COLS_X;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			k_q   <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.look_init) begin
				grp_q <= '0;
				k_q   <= '0;
			end else begin
				if (cmd.issue)
					k_q <= k_q + 1'b1;
				if (cmd.load_out)
					grp_q <= grp_q + 1'b1;
			end
		end
	end

	// column position starts half a step in
	always_ff @(posedge clk) begin
		if (cmd.look_init)
			frac_q <= step_x >> 1;
		else if (cmd.issue)
			frac_q <= frac_q + step_x;
	end

	always_ff @(posedge clk) begin
		if (pix && (cc_x < MAX_COLS_X))
			row_mem[cc_x[AW-1:0]] <= item.pixel;
		row_dat_s1 <= row_mem[idx[AW-1:0]];
		k_s1       <= k_q;
		oob_s1     <= oob;
	end

	always_ff @(posedge clk) begin
		if (accept && !item.kind)
			pal_mem[item.palette_index] <= item.palette_color;
		pal_dat_s2 <= pal_mem[oob_s1 ? 8'd0 : row_dat_s1];
		k_s2       <= k_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s2)
			col_q[k_s2] <= pal_dat_s2;
	end

	assign grp_is_last = grp_q == GRP_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.load_out)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.out_row   <= orow_q;
			res_q.out_group <= 6'(grp_q);
			res_q.color0    <= col_q[0];
			res_q.color1    <= col_q[1];
			res_q.color2    <= col_q[2];
			res_q.color3    <= col_q[3];
			res_q.row_last  <= grp_is_last;
			res_q.frame_end <= grp_is_last && last_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign sts.fire       = fire;
	assign sts.div_done   = div_done;
	assign sts.k_last     = k_q == 2'd3;
	assign sts.pipe_busy  = v_s1 || v_s2;
	assign sts.out_free   = !res_valid_q || result_ready;
	assign sts.group_last = grp_is_last;

endmodule

>>> hdl/pns_ctrl.sv
// Controller: sequences step division, column lookups and result loads per row.
`timescale 1ns / 1ps

module pns_ctrl import pns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pns_sts_t sts,
	output pns_cmd_t cmd,
	output logic     item_ready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.fire) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.look_init = 1'b1;
					state_d       = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// issue one column lookup per cycle, four per group
				cmd.issue = 1'b1;
				if (sts.k_last)
					state_d = ST_WAIT;
			end
			ST_WAIT: begin
				// hold until the lookups have landed and the output slot is free
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sts.group_last ? ST_IDLE : ST_LOOK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> hdl/paletted_nearest_scaler_top.sv
// Top level of the paletted nearest-neighbor scaler with its register port.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_ready   pns_item_t (palette write or pixel)
//   result    out        result_valid / result_ready  pns_result_t (four colors)
//   config    in         APB psel/penable/pwrite   src_cols @0x0, src_rows @0x4
//
// Palette writes and pixels are accepted while item_ready is high. A pixel
// that completes a selected row drops item_ready until that row is done:
// the column step is formed by shift, then each group of four issues four
// row reads through one row memory port and one palette port, waits for
// the lookups to drain and loads the output register.
// A stalled result holds the controller in its wait state; no clearing pass.
// Reset is asynchronous; the memories start undefined.
`timescale 1ns / 1ps

module paletted_nearest_scaler_top import pns_pkg::*; #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024,
	parameter int OUT_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  pns_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output pns_result_t result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(256);

	logic [CFG_W-1:0] src_cols_q;
	logic [CFG_W-1:0] src_rows_q;
	pns_cmd_t         cmd;
	pns_sts_t         sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cols_q <= SIZE_RST;
			src_rows_q <= SIZE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SRC_COLS: src_cols_q <= pwdata[CFG_W-1:0];
				REG_SRC_ROWS: src_rows_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SRC_COLS: prdata = 32'(src_cols_q);
			REG_SRC_ROWS: prdata = 32'(src_rows_q);
			default:      prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	pns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.item_ready(item_ready)
	);

	pns_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.OUT_SIZE(OUT_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.src_cols    (src_cols_q),
		.src_rows    (src_rows_q),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

>>> hdl/pns_chk.sv
// Port-level checker for the scaler top level, attached by bind.
`timescale 1ns / 1ps

module pns_chk import pns_pkg::*; #(
	parameter int OUT_SIZE = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input pns_item_t   item,
	input logic        result_valid,
	input logic        result_ready,
	input pns_result_t result
);

	localparam logic [5:0] GRP_LAST = 6'(OUT_SIZE / 4 - 1);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_end |-> result.row_last)
		else $error("frame end outside the last group of a row");

	a_row_last_grp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.row_last == (result.out_group == GRP_LAST)))
		else $error("row_last does not match the final group");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> $past(item_valid && item_ready && item.kind))
		else $error("input closed without an accepted pixel request");

endmodule

bind paletted_nearest_scaler_top pns_chk #(
	.OUT_SIZE(OUT_SIZE)
) u_pns_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
